[sv/bblur_pkg.sv]
// Shared types, constants and arithmetic helpers for the 3x3 box blur.
`default_nettype none
package bblur_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 4096;

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);

   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 13;
   localparam int CSR_DATA_W   = 13;
   localparam int CSR_INDEX_W  = 1;

   localparam int XCMP_W = (COL_W > WIDTH_REG_W) ? COL_W : WIDTH_REG_W;
   localparam int YCMP_W = (ROW_W > HEIGHT_REG_W) ? ROW_W : HEIGHT_REG_W;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = CSR_INDEX_W'(1);

   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = WIDTH_REG_W'(1024);
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = HEIGHT_REG_W'(768);

   localparam int CHAN_W      = 8;
   localparam int PIX_W       = 3 * CHAN_W;
   localparam int CSUM_W      = 10;
   localparam int SUM_W       = 12;
   localparam int X_W         = 13;
   localparam int RECIP_W     = 16;
   localparam int RECIP_SHIFT = 16;
   localparam int CNT_W       = 4;
   localparam int SEL_W       = 2;
   localparam int NUM_CELLS   = 3;

   typedef struct packed {
      logic [CHAN_W-1:0] red_in;
      logic [CHAN_W-1:0] green_in;
      logic [CHAN_W-1:0] blue_in;
   } req_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red_out;
      logic [CHAN_W-1:0] green_out;
      logic [CHAN_W-1:0] blue_out;
      logic              run_last;
      logic              frame_last;
   } rsp_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } pixel_type;

   // row0: two rows up, row1: one row up, row2: current row
   typedef struct packed {
      pixel_type row0;
      pixel_type row1;
      pixel_type row2;
   } col_type;

   typedef struct packed {
      logic [CSUM_W-1:0] red;
      logic [CSUM_W-1:0] green;
      logic [CSUM_W-1:0] blue;
   } csum_type;

   typedef struct packed {
      logic             shift;
      logic [SEL_W-1:0] rlo;
   } cell_ctl_type;

   typedef struct packed {
      logic             load;
      logic [SEL_W-1:0] rlo;
      logic [SEL_W-1:0] clo;
   } mean_ctl_type;

   function automatic logic [CNT_W-1:0] win_count(logic [SEL_W-1:0] rlo,
                                                  logic [SEL_W-1:0] clo);
      return CNT_W'((3 - int'(rlo)) * (3 - int'(clo)));
   endfunction

   // ceil(2^16 / (2*count)); exact quotient for every reachable numerator
   function automatic logic [RECIP_W-1:0] recip(logic [CNT_W-1:0] cnt);
      logic [RECIP_W-1:0] m;
      unique case (cnt)
         CNT_W'(1): m = RECIP_W'(32768);
         CNT_W'(2): m = RECIP_W'(16384);
         CNT_W'(3): m = RECIP_W'(10923);
         CNT_W'(4): m = RECIP_W'(8192);
         CNT_W'(6): m = RECIP_W'(5462);
         CNT_W'(9): m = RECIP_W'(3641);
         default:   m = '0;
      endcase
      return m;
   endfunction

endpackage
`default_nettype wire

[sv/bblur_cell.sv]
// Window column cell: holds three pixels of one column and passes them on.
`default_nettype none
module bblur_cell (
   input  wire                     clock,
   input  bblur_pkg::cell_ctl_type ctl,
   input  bblur_pkg::col_type      col_in,
   output bblur_pkg::col_type      col_out,
   output bblur_pkg::csum_type     csum
);

   bblur_pkg::col_type col_ff;

   function automatic logic [bblur_pkg::CSUM_W-1:0] col_sum(
      logic [bblur_pkg::SEL_W-1:0]  rlo,
      logic [bblur_pkg::CHAN_W-1:0] a,
      logic [bblur_pkg::CHAN_W-1:0] b,
      logic [bblur_pkg::CHAN_W-1:0] c);
      logic [bblur_pkg::CSUM_W-1:0] s;
      s = bblur_pkg::CSUM_W'(c);
      if (rlo <= bblur_pkg::SEL_W'(1)) s = s + bblur_pkg::CSUM_W'(b);
      if (rlo == bblur_pkg::SEL_W'(0)) s = s + bblur_pkg::CSUM_W'(a);
      return s;
   endfunction

   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         col_ff <= col_in;
      end
   end

   assign col_out    = col_ff;
   assign csum.red   = col_sum(ctl.rlo, col_ff.row0.red, col_ff.row1.red, col_ff.row2.red);
   assign csum.green = col_sum(ctl.rlo, col_ff.row0.green, col_ff.row1.green,
                               col_ff.row2.green);
   assign csum.blue  = col_sum(ctl.rlo, col_ff.row0.blue, col_ff.row1.blue,
                               col_ff.row2.blue);

endmodule
`default_nettype wire

[sv/bblur_mean.sv]
// Window mean: registered column total, then reciprocal multiply per channel.
`default_nettype none
module bblur_mean (
   input  wire                                           clock,
   input  bblur_pkg::mean_ctl_type                       ctl,
   input  bblur_pkg::csum_type [bblur_pkg::NUM_CELLS-1:0] csum,
   output bblur_pkg::pixel_type                          mean
);

   logic [bblur_pkg::X_W-1:0]     xr_ff, xg_ff, xb_ff;
   logic [bblur_pkg::X_W-1:0]     xr_in, xg_in, xb_in;
   logic [bblur_pkg::RECIP_W-1:0] recip_ff;
   logic [bblur_pkg::CNT_W-1:0]   cnt;
   logic [bblur_pkg::X_W+bblur_pkg::RECIP_W-1:0] pr, pg, pb;

   function automatic logic [bblur_pkg::X_W-1:0] numer(
      logic [bblur_pkg::SEL_W-1:0]  clo,
      logic [bblur_pkg::CNT_W-1:0]  n,
      logic [bblur_pkg::CSUM_W-1:0] s0,
      logic [bblur_pkg::CSUM_W-1:0] s1,
      logic [bblur_pkg::CSUM_W-1:0] s2);
      logic [bblur_pkg::SUM_W-1:0] t;
      t = bblur_pkg::SUM_W'(s2);
      if (clo <= bblur_pkg::SEL_W'(1)) t = t + bblur_pkg::SUM_W'(s1);
      if (clo == bblur_pkg::SEL_W'(0)) t = t + bblur_pkg::SUM_W'(s0);
      return {t, 1'b0} + bblur_pkg::X_W'(n);
   endfunction

   assign cnt   = bblur_pkg::win_count(ctl.rlo, ctl.clo);
   assign xr_in = numer(ctl.clo, cnt, csum[0].red, csum[1].red, csum[2].red);
   assign xg_in = numer(ctl.clo, cnt, csum[0].green, csum[1].green, csum[2].green);
   assign xb_in = numer(ctl.clo, cnt, csum[0].blue, csum[1].blue, csum[2].blue);

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         xr_ff    <= xr_in;
         xg_ff    <= xg_in;
         xb_ff    <= xb_in;
         recip_ff <= bblur_pkg::recip(cnt);
      end
   end

   assign pr = xr_ff * recip_ff;
   assign pg = xg_ff * recip_ff;
   assign pb = xb_ff * recip_ff;

   assign mean.red   = pr[bblur_pkg::RECIP_SHIFT +: bblur_pkg::CHAN_W];
   assign mean.green = pg[bblur_pkg::RECIP_SHIFT +: bblur_pkg::CHAN_W];
   assign mean.blue  = pb[bblur_pkg::RECIP_SHIFT +: bblur_pkg::CHAN_W];

endmodule
`default_nettype wire

[sv/box_blur_3x3_clamped.sv]
// Top level: streaming 3x3 box blur with edge clipping, line store and control.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  req_data  (rgb pixel)
//   rsp      out        rsp_valid/rsp_ready  rsp_data  (rgb mean, run/frame last)
//   csr      in         csr_write_en         csr_index, csr_wdata
//
// An item gives n = 0..4 results: the idle state reads the line store, the load
// state shifts the window cells and writes the line store back, and each
// result takes a sum state and a multiply state into the output register.
// Reset clears counters, control and rsp_valid; data and line store are kept.
// A stalled rsp holds the sequencer in its multiply state.
`default_nettype none
module box_blur_3x3_clamped (
   input  wire                                     clock,
   input  wire                                     reset,
   input  wire                                     req_valid,
   output logic                                    req_ready,
   input  bblur_pkg::req_type                      req_data,
   output logic                                    rsp_valid,
   input  wire                                     rsp_ready,
   output bblur_pkg::rsp_type                      rsp_data,
   input  wire                                     csr_write_en,
   input  wire  [bblur_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  wire  [bblur_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_LOAD = 2'd1;
   localparam logic [1:0] ST_SUM  = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   typedef struct packed {
      logic r_ge1;
      logic r_ge2;
      logic c_ge1;
      logic c_ge2;
      logic row_end;
      logic last_row;
   } flags_type;

   logic [1:0] state_ff, state_in;

   logic [bblur_pkg::WIDTH_REG_W-1:0]  width_ff;
   logic [bblur_pkg::HEIGHT_REG_W-1:0] height_ff;
   logic [bblur_pkg::WIDTH_REG_W-1:0]  w_eff;
   logic [bblur_pkg::HEIGHT_REG_W-1:0] h_eff;

   logic [bblur_pkg::COL_W-1:0] col_ff, cur_col_ff;
   logic [bblur_pkg::ROW_W-1:0] row_ff;
   logic                        par_ff;
   flags_type                   flags_in, flags_ff;

   logic [2*bblur_pkg::PIX_W-1:0] line_mem [bblur_pkg::MAX_WIDTH];
   logic [2*bblur_pkg::PIX_W-1:0] rd_ff, wr_entry;
   bblur_pkg::pixel_type          pix_ff, above2, above1;

   logic [3:0] pend_ff, pend_in, pend_rest;
   logic       last_ff, frame_ff;
   logic [bblur_pkg::SEL_W-1:0] ra, rb, ca, cb, rlo, clo;

   bblur_pkg::col_type [bblur_pkg::NUM_CELLS-1:0]  cell_in, cell_out;
   bblur_pkg::csum_type [bblur_pkg::NUM_CELLS-1:0] csum;
   bblur_pkg::cell_ctl_type cell_ctl;
   bblur_pkg::mean_ctl_type mean_ctl;
   bblur_pkg::pixel_type    mean;

   bblur_pkg::rsp_type rsp_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               req_fire, emit_fire, out_free;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= bblur_pkg::WIDTH_RESET;
         height_ff <= bblur_pkg::HEIGHT_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            bblur_pkg::CSR_IMAGE_WIDTH:
               width_ff <= csr_wdata[bblur_pkg::WIDTH_REG_W-1:0];
            bblur_pkg::CSR_IMAGE_HEIGHT:
               height_ff <= csr_wdata[bblur_pkg::HEIGHT_REG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      priority if (width_ff == '0) begin
         w_eff = bblur_pkg::WIDTH_REG_W'(1);
      end else if (width_ff > bblur_pkg::WIDTH_REG_W'(bblur_pkg::MAX_WIDTH)) begin
         w_eff = bblur_pkg::WIDTH_REG_W'(bblur_pkg::MAX_WIDTH);
      end else begin
         w_eff = width_ff;
      end
      priority if (height_ff == '0) begin
         h_eff = bblur_pkg::HEIGHT_REG_W'(1);
      end else if (height_ff > bblur_pkg::HEIGHT_REG_W'(bblur_pkg::MAX_HEIGHT)) begin
         h_eff = bblur_pkg::HEIGHT_REG_W'(bblur_pkg::MAX_HEIGHT);
      end else begin
         h_eff = height_ff;
      end
   end

   assign flags_in.r_ge1    = row_ff >= bblur_pkg::ROW_W'(1);
   assign flags_in.r_ge2    = row_ff >= bblur_pkg::ROW_W'(2);
   assign flags_in.c_ge1    = col_ff >= bblur_pkg::COL_W'(1);
   assign flags_in.c_ge2    = col_ff >= bblur_pkg::COL_W'(2);
   assign flags_in.row_end  = bblur_pkg::XCMP_W'(col_ff) >=
                              bblur_pkg::XCMP_W'(w_eff - bblur_pkg::WIDTH_REG_W'(1));
   assign flags_in.last_row = bblur_pkg::YCMP_W'(row_ff) >=
                              bblur_pkg::YCMP_W'(h_eff - bblur_pkg::HEIGHT_REG_W'(1));

   assign req_ready = state_ff == ST_IDLE;
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign emit_fire = (state_ff == ST_EMIT) && out_free;

   // position counters
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (req_fire) begin
         if (flags_in.row_end) begin
            col_ff <= '0;
            row_ff <= flags_in.last_row ? '0 : row_ff + bblur_pkg::ROW_W'(1);
         end else begin
            col_ff <= col_ff + bblur_pkg::COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         flags_ff   <= flags_in;
         cur_col_ff <= col_ff;
         par_ff     <= row_ff[0];
         pix_ff     <= {req_data.red_in, req_data.green_in, req_data.blue_in};
      end
   end

   // line store: one entry per column holds both stored rows
   assign above2   = par_ff ? rd_ff[2*bblur_pkg::PIX_W-1:bblur_pkg::PIX_W]
                            : rd_ff[bblur_pkg::PIX_W-1:0];
   assign above1   = par_ff ? rd_ff[bblur_pkg::PIX_W-1:0]
                            : rd_ff[2*bblur_pkg::PIX_W-1:bblur_pkg::PIX_W];
   assign wr_entry = par_ff ? {pix_ff, rd_ff[bblur_pkg::PIX_W-1:0]}
                            : {rd_ff[2*bblur_pkg::PIX_W-1:bblur_pkg::PIX_W], pix_ff};

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rd_ff <= line_mem[col_ff];
      end
      if (state_ff == ST_LOAD) begin
         line_mem[cur_col_ff] <= wr_entry;
      end
   end

   // window cells
   assign cell_ctl.shift = state_ff == ST_LOAD;
   assign cell_ctl.rlo   = rlo;

   assign cell_in[2].row0 = above2;
   assign cell_in[2].row1 = above1;
   assign cell_in[2].row2 = pix_ff;
   assign cell_in[1]      = cell_out[2];
   assign cell_in[0]      = cell_out[1];

   for (genvar k = 0; k < bblur_pkg::NUM_CELLS; k++) begin : g_cell
      bblur_cell u_cell (
         .clock   (clock),
         .ctl     (cell_ctl),
         .col_in  (cell_in[k]),
         .col_out (cell_out[k]),
         .csum    (csum[k])
      );
   end

   // result schedule: bit 0 upper row left, 1 upper row right edge,
   // 2 last row left, 3 last row right edge
   assign pend_in = {flags_ff.last_row && flags_ff.row_end,
                     flags_ff.last_row && flags_ff.c_ge1,
                     flags_ff.r_ge1 && flags_ff.row_end,
                     flags_ff.r_ge1 && flags_ff.c_ge1};
   assign pend_rest = pend_ff & (pend_ff - 4'd1);

   assign ra = flags_ff.r_ge2 ? bblur_pkg::SEL_W'(0) : bblur_pkg::SEL_W'(1);
   assign rb = flags_ff.r_ge1 ? bblur_pkg::SEL_W'(1) : bblur_pkg::SEL_W'(2);
   assign ca = flags_ff.c_ge2 ? bblur_pkg::SEL_W'(0) : bblur_pkg::SEL_W'(1);
   assign cb = flags_ff.c_ge1 ? bblur_pkg::SEL_W'(1) : bblur_pkg::SEL_W'(2);

   always_comb begin
      priority if (pend_ff[0]) begin
         rlo = ra;
         clo = ca;
      end else if (pend_ff[1]) begin
         rlo = ra;
         clo = cb;
      end else if (pend_ff[2]) begin
         rlo = rb;
         clo = ca;
      end else begin
         rlo = rb;
         clo = cb;
      end
   end

   assign mean_ctl.load = state_ff == ST_SUM;
   assign mean_ctl.rlo  = rlo;
   assign mean_ctl.clo  = clo;

   bblur_mean u_mean (
      .clock (clock),
      .ctl   (mean_ctl),
      .csum  (csum),
      .mean  (mean)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_fire) state_in = ST_LOAD;
         ST_LOAD: state_in = (pend_in == '0) ? ST_IDLE : ST_SUM;
         ST_SUM:  state_in = ST_EMIT;
         ST_EMIT: if (out_free) state_in = (pend_ff == '0) ? ST_IDLE : ST_SUM;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pend_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_LOAD) begin
            pend_ff <= pend_in;
         end else if (state_ff == ST_SUM) begin
            pend_ff <= pend_rest;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_SUM) begin
         last_ff  <= pend_rest == '0;
         frame_ff <= (pend_rest == '0) && flags_ff.last_row && flags_ff.row_end;
      end
   end

   // output register
   assign rsp_valid_in = emit_fire ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_fire) begin
         rsp_ff.red_out    <= mean.red;
         rsp_ff.green_out  <= mean.green;
         rsp_ff.blue_out   <= mean.blue;
         rsp_ff.run_last   <= last_ff;
         rsp_ff.frame_last <= frame_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

[tb/sv/box_blur_3x3_clamped_tb.sv]
// Self-checking testbench for the streaming 3x3 clipped box blur.
`timescale 1ns / 100ps
module box_blur_3x3_clamped_tb;

   localparam int unsigned DRAIN_CYCLES = 16;
   localparam int unsigned QUIET_LIMIT  = 4000;
   localparam int unsigned RANDOM_ITEMS = 220;

   typedef enum logic {PIX_RANDOM, PIX_PATTERN} pix_mode_type;

   logic                                  clock = 1'b0;
   logic                                  reset = 1'b1;
   logic                                  req_valid = 1'b0;
   logic                                  req_ready;
   bblur_pkg::req_type                    req_data = '0;
   logic                                  rsp_valid;
   logic                                  rsp_ready = 1'b0;
   bblur_pkg::rsp_type                    rsp_data;
   logic                                  csr_write_en = 1'b0;
   logic [bblur_pkg::CSR_INDEX_W-1:0]     csr_index = '0;
   logic [bblur_pkg::CSR_DATA_W-1:0]      csr_wdata = '0;

   // blur predictor state
   bblur_pkg::pixel_type                  line_mem [0:2*bblur_pkg::MAX_WIDTH-1];
   bblur_pkg::pixel_type                  win [0:8];
   int unsigned                           col_pos = 0;
   int unsigned                           row_pos = 0;
   logic [bblur_pkg::WIDTH_REG_W-1:0]     width_reg = bblur_pkg::WIDTH_RESET;
   logic [bblur_pkg::HEIGHT_REG_W-1:0]    height_reg = bblur_pkg::HEIGHT_RESET;

   bblur_pkg::req_type                    pending_pixels [$];
   bblur_pkg::rsp_type                    expected_blur [$];
   bblur_pkg::rsp_type                    want_rsp;
   int unsigned                           req_wait = 0;
   int unsigned                           req_calm = 0;
   int unsigned                           rsp_hold = 0;
   int unsigned                           rsp_calm = 0;
   int unsigned                           quiet_cycles = 0;
   int unsigned                           error_count = 0;
   int unsigned                           pattern_idx = 0;

   box_blur_3x3_clamped dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int unsigned eff_width();
      int unsigned w;
      w = width_reg;
      if (w < 1) w = 1;
      if (w > bblur_pkg::MAX_WIDTH) w = bblur_pkg::MAX_WIDTH;
      return w;
   endfunction

   function automatic int unsigned eff_height();
      int unsigned h;
      h = height_reg;
      if (h < 1) h = 1;
      if (h > bblur_pkg::MAX_HEIGHT) h = bblur_pkg::MAX_HEIGHT;
      return h;
   endfunction

   function automatic int unsigned frame_remaining();
      int unsigned w, h, row_left, rows_after;
      w = eff_width();
      h = eff_height();
      row_left = (col_pos >= w - 1) ? 1 : w - col_pos;
      rows_after = (row_pos >= h - 1) ? 0 : h - 1 - row_pos;
      return row_left + rows_after * w;
   endfunction

   function automatic bblur_pkg::rsp_type window_mean(int rlo, int clo);
      int                 i, j, sum_r, sum_g, sum_b, cnt;
      bblur_pkg::rsp_type res;
      sum_r = 0;
      sum_g = 0;
      sum_b = 0;
      cnt = 0;
      for (i = rlo; i <= 2; i++) begin
         for (j = clo; j <= 2; j++) begin
            sum_r += win[i*3+j].red;
            sum_g += win[i*3+j].green;
            sum_b += win[i*3+j].blue;
            cnt++;
         end
      end
      res.red_out    = 8'((2 * sum_r + cnt) / (2 * cnt));
      res.green_out  = 8'((2 * sum_g + cnt) / (2 * cnt));
      res.blue_out   = 8'((2 * sum_b + cnt) / (2 * cnt));
      res.run_last   = 1'b0;
      res.frame_last = 1'b0;
      return res;
   endfunction

   function automatic void blur_pixel(bblur_pkg::req_type px);
      int unsigned          w, h, r, c, k;
      int                   rlo;
      bit                   row_end, last_row;
      bblur_pkg::pixel_type pin, up2, up1;
      bblur_pkg::rsp_type   res [$];
      bblur_pkg::rsp_type   tail;
      w = eff_width();
      h = eff_height();
      r = row_pos;
      c = col_pos;
      if (c >= bblur_pkg::MAX_WIDTH) c = bblur_pkg::MAX_WIDTH - 1;
      row_end = c >= w - 1;
      last_row = r >= h - 1;
      pin.red = px.red_in;
      pin.green = px.green_in;
      pin.blue = px.blue_in;
      up2 = line_mem[(r % 2) * bblur_pkg::MAX_WIDTH + c];
      up1 = line_mem[((r + 1) % 2) * bblur_pkg::MAX_WIDTH + c];
      line_mem[(r % 2) * bblur_pkg::MAX_WIDTH + c] = pin;
      for (k = 0; k < 3; k++) begin
         win[k*3]   = win[k*3+1];
         win[k*3+1] = win[k*3+2];
      end
      win[2] = up2;
      win[5] = up1;
      win[8] = pin;
      if (r >= 1) begin
         rlo = (r >= 2) ? 0 : 1;
         if (c >= 1) res.push_back(window_mean(rlo, (c >= 2) ? 0 : 1));
         if (row_end) res.push_back(window_mean(rlo, (c >= 1) ? 1 : 2));
      end
      if (last_row) begin
         rlo = (r >= 1) ? 1 : 2;
         if (c >= 1) res.push_back(window_mean(rlo, (c >= 2) ? 0 : 1));
         if (row_end) res.push_back(window_mean(rlo, (c >= 1) ? 1 : 2));
      end
      if (res.size() != 0) begin
         tail = res.pop_back();
         tail.run_last = 1'b1;
         tail.frame_last = last_row && row_end;
         res.push_back(tail);
      end
      for (k = 0; k < res.size(); k++) expected_blur.push_back(res[k]);
      if (row_end) begin
         col_pos = 0;
         row_pos = last_row ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
      end
   endfunction

   function automatic int unsigned pick_gap(inout int unsigned calm);
      int unsigned roll;
      if (calm != 0) begin
         calm--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
         calm = $urandom_range(20, 80);
         return 0;
      end
      if (roll < 50) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 8);
      return $urandom_range(15, 40);
   endfunction

   function automatic logic [7:0] rand_chan();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
         error_count++;
      end
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            blur_pixel(req_data);
            req_wait = pick_gap(req_calm);
         end
         if (!req_valid || req_ready) begin
            if (req_wait != 0) begin
               req_wait--;
               req_valid <= 1'b0;
            end else if (pending_pixels.size() != 0) begin
               req_data <= pending_pixels.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_blur.size() == 0) begin
               $display("%0t: result expected none, actual %p", $time, rsp_data);
               error_count++;
            end else begin
               want_rsp = expected_blur.pop_front();
               check_field("red_out", want_rsp.red_out, rsp_data.red_out);
               check_field("green_out", want_rsp.green_out, rsp_data.green_out);
               check_field("blue_out", want_rsp.blue_out, rsp_data.blue_out);
               check_field("run_last", want_rsp.run_last, rsp_data.run_last);
               check_field("frame_last", want_rsp.frame_last, rsp_data.frame_last);
            end
         end
         if (rsp_hold != 0) begin
            rsp_hold--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            rsp_hold = pick_gap(rsp_calm);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_en) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

   task automatic write_csr(logic [bblur_pkg::CSR_INDEX_W-1:0] idx, int unsigned value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= bblur_pkg::CSR_DATA_W'(value);
      @(posedge clock);
      csr_write_en <= 1'b0;
      if (idx == bblur_pkg::CSR_IMAGE_WIDTH) width_reg = bblur_pkg::WIDTH_REG_W'(value);
      else height_reg = bblur_pkg::HEIGHT_REG_W'(value);
   endtask

   task automatic queue_pixels(int unsigned count, pix_mode_type mode);
      bblur_pkg::req_type px;
      int unsigned        k;
      @(negedge clock);
      for (k = 0; k < count; k++) begin
         if (mode == PIX_PATTERN) begin
            px.red_in = (pattern_idx % 2 != 0) ? 8'hFF : 8'h00;
            px.green_in = (pattern_idx % 3 == 0) ? 8'hFF : 8'h00;
            px.blue_in = 8'(pattern_idx * 37 + 1);
            pattern_idx++;
         end else begin
            px.red_in = rand_chan();
            px.green_in = rand_chan();
            px.blue_in = rand_chan();
         end
         pending_pixels.push_back(px);
      end
   endtask

   // wait for the block to go idle
   task automatic settle();
      do @(negedge clock);
      while (pending_pixels.size() != 0 || req_valid || expected_blur.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      int unsigned sent, total, part, k;
      for (k = 0; k < 2 * bblur_pkg::MAX_WIDTH; k++) line_mem[k] = '0;
      for (k = 0; k < 9; k++) win[k] = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // full small frame
      write_csr(bblur_pkg::CSR_IMAGE_WIDTH, 3);
      write_csr(bblur_pkg::CSR_IMAGE_HEIGHT, 3);
      queue_pixels(frame_remaining(), PIX_PATTERN);
      settle();
      // zero sizes act as one
      write_csr(bblur_pkg::CSR_IMAGE_WIDTH, 0);
      write_csr(bblur_pkg::CSR_IMAGE_HEIGHT, 0);
      queue_pixels(2, PIX_PATTERN);
      settle();
      // oversized height, then cut the frame short
      write_csr(bblur_pkg::CSR_IMAGE_WIDTH, 2);
      write_csr(bblur_pkg::CSR_IMAGE_HEIGHT, 8191);
      queue_pixels(4, PIX_PATTERN);
      settle();
      write_csr(bblur_pkg::CSR_IMAGE_HEIGHT, 1);
      queue_pixels(frame_remaining(), PIX_PATTERN);
      settle();
      // shrink width in the middle of a row
      write_csr(bblur_pkg::CSR_IMAGE_WIDTH, 4);
      write_csr(bblur_pkg::CSR_IMAGE_HEIGHT, 2);
      queue_pixels(2, PIX_PATTERN);
      settle();
      write_csr(bblur_pkg::CSR_IMAGE_WIDTH, 2);
      queue_pixels(frame_remaining(), PIX_PATTERN);
      settle();

      // oversized width and tallest height, each cut short
      write_csr(bblur_pkg::CSR_IMAGE_WIDTH, 2047);
      write_csr(bblur_pkg::CSR_IMAGE_HEIGHT, 2);
      queue_pixels(5, PIX_RANDOM);
      settle();
      write_csr(bblur_pkg::CSR_IMAGE_WIDTH, 3);
      queue_pixels(frame_remaining(), PIX_RANDOM);
      settle();
      write_csr(bblur_pkg::CSR_IMAGE_WIDTH, 1);
      write_csr(bblur_pkg::CSR_IMAGE_HEIGHT, bblur_pkg::MAX_HEIGHT);
      queue_pixels(6, PIX_RANDOM);
      settle();
      write_csr(bblur_pkg::CSR_IMAGE_HEIGHT, 0);
      queue_pixels(frame_remaining(), PIX_RANDOM);

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         settle();
         write_csr(bblur_pkg::CSR_IMAGE_WIDTH, ($urandom_range(0, 15) == 0) ? 0 :
                   ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8));
         write_csr(bblur_pkg::CSR_IMAGE_HEIGHT, ($urandom_range(0, 15) == 0) ? 0 :
                   ($urandom_range(0, 7) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8));
         total = frame_remaining();
         if (total > 1 && $urandom_range(0, 3) == 0) begin
            part = $urandom_range(1, total - 1);
            queue_pixels(part, PIX_RANDOM);
            sent += part;
            settle();
            if ($urandom_range(0, 1) == 0) begin
               write_csr(bblur_pkg::CSR_IMAGE_HEIGHT, $urandom_range(0, 12));
            end else begin
               write_csr(bblur_pkg::CSR_IMAGE_WIDTH, $urandom_range(0, eff_width()));
            end
            total = frame_remaining();
         end
         queue_pixels(total, PIX_RANDOM);
         sent += total;
      end

      settle();
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
